FILE: hdl/gpa_pkg.sv
// Package for the gated pose averager: widths, reset values, register
// indexes, controller states and the lane control/result structs.
// No dependencies.
package gpa_pkg;

  localparam int CW        = 32;          // pose component width
  localparam int SW        = CW + 8;      // running sum width
  localparam int NCOMP     = 6;           // trans x,y,z then rot x,y,z
  localparam int GATE_N    = 3;           // components per gate
  localparam int THR_W     = 16;
  localparam int CNT_W     = 8;
  localparam int SQ_W      = 2 * THR_W;
  localparam int ACC_W     = SQ_W + 2;
  localparam int DIFF_W    = CW + 1;
  localparam int STEP_W    = $clog2(SW);
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] TRANS_THR_RST = THR_W'(1966);
  localparam logic [THR_W-1:0] ROT_THR_RST   = THR_W'(6554);
  localparam logic [CNT_W-1:0] COUNT_CAP_RST = CNT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANS_THR = 2'd0,
    CFG_ROT_THR   = 2'd1,
    CFG_COUNT_CAP = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MEAN,
    ST_DIFF,
    ST_SQ,
    ST_GATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // latch incoming sample
    logic seed_in;   // sum <= incoming sample
    logic seed_own;  // sum <= latched sample
    logic add;       // sum <= sum + latched sample
    logic start;     // load divider
    logic step;      // one divider step
    logic mean;      // register signed mean
    logic diff;      // register |mean - sample|
    logic sq;        // register gate flag and square
  } lane_ctl_t;

  typedef struct packed {
    logic            big;
    logic [SQ_W-1:0] sq;
  } lane_res_t;

endpackage

FILE: hdl/gpa_in_if.sv
// Input channel of the gated pose averager: valid/ready and one pose sample.
// Depends on gpa_pkg.
interface gpa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        marker_seen;
  logic signed [gpa_pkg::CW-1:0] trans_x;
  logic signed [gpa_pkg::CW-1:0] trans_y;
  logic signed [gpa_pkg::CW-1:0] trans_z;
  logic signed [gpa_pkg::CW-1:0] rot_x;
  logic signed [gpa_pkg::CW-1:0] rot_y;
  logic signed [gpa_pkg::CW-1:0] rot_z;

  modport source (output valid, marker_seen, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
                  input ready);
  modport sink (input valid, marker_seen, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
                output ready);
endinterface

FILE: hdl/gpa_out_if.sv
// Result channel of the gated pose averager: valid/ready and one emitted pose.
// Depends on gpa_pkg.
interface gpa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        from_mean;
  logic signed [gpa_pkg::CW-1:0] out_trans_x;
  logic signed [gpa_pkg::CW-1:0] out_trans_y;
  logic signed [gpa_pkg::CW-1:0] out_trans_z;
  logic signed [gpa_pkg::CW-1:0] out_rot_x;
  logic signed [gpa_pkg::CW-1:0] out_rot_y;
  logic signed [gpa_pkg::CW-1:0] out_rot_z;

  modport source (output valid, from_mean, out_trans_x, out_trans_y, out_trans_z,
                  out_rot_x, out_rot_y, out_rot_z, input ready);
  modport sink (input valid, from_mean, out_trans_x, out_trans_y, out_trans_z,
                out_rot_x, out_rot_y, out_rot_z, output ready);
endinterface

FILE: hdl/gpa_lane.sv
// One component lane: running sum, bit-serial divider for the mean,
// distance and square for the gate. Depends on gpa_pkg.
module gpa_lane (
  input  logic                          clk,
  input  gpa_pkg::lane_ctl_t            ctl,
  input  logic signed [gpa_pkg::CW-1:0] smp_in,
  input  logic [gpa_pkg::CNT_W-1:0]     cnt,
  input  logic [gpa_pkg::THR_W-1:0]     thr,
  output logic signed [gpa_pkg::CW-1:0] smp,
  output logic signed [gpa_pkg::CW-1:0] mean,
  output gpa_pkg::lane_res_t            res
);
  import gpa_pkg::*;

  logic signed [SW-1:0]   sum_r;
  logic signed [CW-1:0]   smp_r;
  logic signed [CW-1:0]   mean_r;
  logic [SW-1:0]          quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic                   neg_r;
  logic [DIFF_W-1:0]      diff_r;
  lane_res_t              res_r;

  logic [SW-1:0]          mag;
  logic [CNT_W:0]         rem_sh;
  logic [CNT_W:0]         rem_sub;
  logic                   fits;
  logic [SW-1:0]          mean_full;
  logic [DIFF_W-1:0]      d_ms;
  logic [DIFF_W-1:0]      d_sm;
  logic [THR_W-1:0]       d_lo;
  logic [SQ_W-1:0]        sq_c;
  logic [SW-1:0]          smp_in_x;
  logic [SW-1:0]          smp_r_x;

  always_comb begin
    smp_in_x  = {{(SW-CW){smp_in[CW-1]}}, smp_in};
    smp_r_x   = {{(SW-CW){smp_r[CW-1]}}, smp_r};
    mag       = sum_r[SW-1] ? (~$unsigned(sum_r) + 1'b1) : $unsigned(sum_r);
    rem_sh    = {rem_r, quo_r[SW-1]};
    rem_sub   = rem_sh - {1'b0, cnt};
    fits      = (rem_sh >= {1'b0, cnt});
    mean_full = neg_r ? (~quo_r + 1'b1) : quo_r;
    d_ms      = {mean_r[CW-1], mean_r} - {smp_r[CW-1], smp_r};
    d_sm      = {smp_r[CW-1], smp_r} - {mean_r[CW-1], mean_r};
    d_lo      = diff_r[THR_W-1:0];
    sq_c      = SQ_W'(d_lo) * SQ_W'(d_lo);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smp_r <= smp_in;
    end
    if (ctl.seed_in) begin
      sum_r <= $signed(smp_in_x);
    end else if (ctl.seed_own) begin
      sum_r <= $signed(smp_r_x);
    end else if (ctl.add) begin
      sum_r <= sum_r + $signed(smp_r_x);
    end
    // restoring division of |sum| by the count, one quotient bit a step
    if (ctl.start) begin
      quo_r <= mag;
      rem_r <= '0;
      neg_r <= sum_r[SW-1];
    end else if (ctl.step) begin
      rem_r <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[SW-2:0], fits};
    end
    if (ctl.mean) begin
      mean_r <= $signed(mean_full[CW-1:0]);
    end
    if (ctl.diff) begin
      diff_r <= d_ms[DIFF_W-1] ? d_sm : d_ms;
    end
    if (ctl.sq) begin
      res_r.big <= (diff_r >= DIFF_W'(thr));
      res_r.sq  <= sq_c;
    end
  end

  assign smp  = smp_r;
  assign mean = mean_r;
  assign res  = res_r;

endmodule

FILE: hdl/gpa_gate.sv
// Merge stage of one gate: sums three lane squares, compares against the
// squared threshold and checks the big flags. Depends on gpa_pkg.
module gpa_gate (
  input  logic                       clk,
  input  logic                       en,
  input  gpa_pkg::lane_res_t         res [gpa_pkg::GATE_N],
  input  logic [gpa_pkg::SQ_W-1:0]   thr_sq,
  output logic                       close
);
  import gpa_pkg::*;

  logic [ACC_W-1:0] acc;
  logic             any_big;
  logic             close_r;

  always_comb begin
    acc     = ACC_W'(res[0].sq) + ACC_W'(res[1].sq) + ACC_W'(res[2].sq);
    any_big = res[0].big | res[1].big | res[2].big;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      close_r <= !any_big && (acc < ACC_W'(thr_sq));
    end
  end

  assign close = close_r;

endmodule

FILE: hdl/gated_pose_averager.sv
// Gated pose averager top level: controller, configuration registers,
// six component lanes, two gate merges and the result register.
// Depends on gpa_pkg, gpa_in_if, gpa_out_if, gpa_lane and gpa_gate.
//
// Use: a pose sample arrives as one beat on in_pose (marker_seen, three
// translation and three rotation components, Q16.16). Each beat with a
// marker, or without one while an average exists, yields one beat on
// out_pose: the raw sample (from_mean = 0) or the held mean (from_mean = 1).
// A beat without a marker and with an empty average is dropped at once and
// produces nothing.
// Timing: an accepted beat passes through START, the divider steps (DIV),
// MEAN, DIFF, SQ, GATE and EMIT before its result is loaded into the output
// register; the block then returns to idle and takes the next beat, so it
// takes no new beat until the last is through. Each lane's divider has 40 steps.
// in_pose.ready is high only while idle. A loaded result waits in the
// output register while the sink stalls; the next beat may be accepted and
// worked on meanwhile, and its result is held back until the register frees.
// Reset (rst_n low, synchronous) empties the average, drops any pending
// result and restores the default gates and count cap. Write cfg_* only
// while the block is idle.
module gated_pose_averager (
  input  logic                               clk,
  input  logic                               rst_n,
  gpa_in_if.sink                             in_pose,
  gpa_out_if.source                          out_pose,
  input  logic                               cfg_we,
  input  logic [gpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpa_pkg::THR_W-1:0]          cfg_wdata
);
  import gpa_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                marker_r, marker_nxt;

  logic [THR_W-1:0]    trans_thr_r, rot_thr_r;
  logic [CNT_W-1:0]    cap_r;
  logic [SQ_W-1:0]     trans_thr_sq_r, rot_thr_sq_r;

  logic                out_valid_r;
  logic                from_mean_r;
  logic signed [CW-1:0] out_comp_r [NCOMP];

  lane_ctl_t           ctl;
  logic                gate_en;
  logic                emit_go;
  logic                mean_sel;
  logic                in_fire;
  logic                out_free;
  logic                trans_close, rot_close, close;
  logic                below_cap;

  logic signed [CW-1:0] smp_in   [NCOMP];
  logic signed [CW-1:0] lane_smp [NCOMP];
  logic signed [CW-1:0] lane_mean[NCOMP];
  lane_res_t            lane_res [NCOMP];
  lane_res_t            trans_res[GATE_N];
  lane_res_t            rot_res  [GATE_N];

  assign smp_in[0] = in_pose.trans_x;
  assign smp_in[1] = in_pose.trans_y;
  assign smp_in[2] = in_pose.trans_z;
  assign smp_in[3] = in_pose.rot_x;
  assign smp_in[4] = in_pose.rot_y;
  assign smp_in[5] = in_pose.rot_z;

  assign in_pose.ready = (state_r == ST_IDLE);
  assign in_fire       = in_pose.valid && (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_pose.ready;
  assign close         = trans_close && rot_close;
  assign below_cap     = (cnt_r < cap_r);

  // Configuration registers; the squared gates are registered from them on the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_thr_r <= TRANS_THR_RST;
      rot_thr_r   <= ROT_THR_RST;
      cap_r       <= COUNT_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANS_THR: trans_thr_r <= cfg_wdata;
        CFG_ROT_THR:   rot_thr_r   <= cfg_wdata;
        CFG_COUNT_CAP: cap_r       <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    trans_thr_sq_r <= SQ_W'(trans_thr_r) * SQ_W'(trans_thr_r);
    rot_thr_sq_r   <= SQ_W'(rot_thr_r) * SQ_W'(rot_thr_r);
  end

  // Lanes: trans x,y,z share the translation gate, rot x,y,z the rotation one.
  for (genvar i = 0; i < NCOMP; i++) begin : g_lane
    gpa_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .smp_in (smp_in[i]),
      .cnt    (cnt_r),
      .thr    ((i < GATE_N) ? trans_thr_r : rot_thr_r),
      .smp    (lane_smp[i]),
      .mean   (lane_mean[i]),
      .res    (lane_res[i])
    );
  end

  always_comb begin
    for (int k = 0; k < GATE_N; k++) begin
      trans_res[k] = lane_res[k];
      rot_res[k]   = lane_res[k + GATE_N];
    end
  end

  gpa_gate u_trans_gate (
    .clk    (clk),
    .en     (gate_en),
    .res    (trans_res),
    .thr_sq (trans_thr_sq_r),
    .close  (trans_close)
  );

  gpa_gate u_rot_gate (
    .clk    (clk),
    .en     (gate_en),
    .res    (rot_res),
    .thr_sq (rot_thr_sq_r),
    .close  (rot_close)
  );

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      step_r   <= '0;
      marker_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      step_r   <= step_nxt;
      marker_r <= marker_nxt;
    end
  end

  // Next state and lane commands.
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    marker_nxt = marker_r;
    ctl        = '0;
    gate_en    = 1'b0;
    emit_go    = 1'b0;
    mean_sel   = !marker_r || (close && !below_cap);
    case (state_r)
      ST_IDLE: begin
        // drop a markerless beat when there is no average to repeat
        if (in_fire && (in_pose.marker_seen || (cnt_r != '0))) begin
          ctl.load   = 1'b1;
          marker_nxt = in_pose.marker_seen;
          if (in_pose.marker_seen && (cnt_r == '0)) begin
            ctl.seed_in = 1'b1;
            cnt_nxt     = CNT_W'(1);
          end
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        ctl.start = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SW - 1)) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        ctl.mean  = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        ctl.diff  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        ctl.sq    = 1'b1;
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        gate_en   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register frees, then add to or reseed the average where gate and cap call for it
        if (out_free) begin
          emit_go = 1'b1;
          if (marker_r && close && below_cap) begin
            ctl.add = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else if (marker_r && !close) begin
            ctl.seed_own = 1'b1;
            cnt_nxt      = CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register: advance on a new result, clear once the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_pose.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      from_mean_r <= mean_sel;
      for (int k = 0; k < NCOMP; k++) begin
        out_comp_r[k] <= mean_sel ? lane_mean[k] : lane_smp[k];
      end
    end
  end

  assign out_pose.valid       = out_valid_r;
  assign out_pose.from_mean   = from_mean_r;
  assign out_pose.out_trans_x = out_comp_r[0];
  assign out_pose.out_trans_y = out_comp_r[1];
  assign out_pose.out_trans_z = out_comp_r[2];
  assign out_pose.out_rot_x   = out_comp_r[3];
  assign out_pose.out_rot_y   = out_comp_r[4];
  assign out_pose.out_rot_z   = out_comp_r[5];

`ifndef ASSERT_OFF
  // a fresh result only ever comes from the emit step
  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_EMIT))
    else $error("result register loaded outside the emit step");

  // the divider never runs against an empty count
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("division started with a zero sample count");

  // a marker beat always leaves a non-empty average behind
  a_marker_keeps_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && marker_r) |=> (cnt_r != '0))
    else $error("sample count empty after a marker beat");
`endif

endmodule

FILE: bench/gpa_average_checker.sv
// Checker for the gated pose averager: watches the input, result and
// configuration ports, predicts every result beat and compares it field by field.
// Depends on gpa_pkg, gpa_in_if and gpa_out_if.
module gpa_average_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  gpa_in_if                             in_pose,
  gpa_out_if                            out_pose,
  input  logic                          cfg_we,
  input  logic [gpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpa_pkg::THR_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            pending
);
  import gpa_pkg::*;

  typedef logic [NCOMP-1:0][CW-1:0] pose_t;
  typedef struct packed {
    logic  from_mean;
    pose_t comp;
  } pose_beat_t;

  logic [THR_W-1:0] trans_gate;
  logic [THR_W-1:0] rot_gate;
  logic [CNT_W-1:0] hold_cap;
  logic [CNT_W-1:0] n_held;
  longint           pose_sum [NCOMP];
  pose_beat_t       poses_due [$];
  string            comp_name [NCOMP] = '{"trans_x", "trans_y", "trans_z",
                                          "rot_x", "rot_y", "rot_z"};

  // Mean of the running sums, truncated toward zero.
  function automatic void mean_of(output longint avg [NCOMP]);
    for (int k = 0; k < NCOMP; k++)
      avg[k] = pose_sum[k] / longint'(n_held);
  endfunction

  // True when every distance over one half of the pose is below thr and their squares sum below thr^2.
  function automatic bit gate_open(input longint avg [NCOMP], input longint smp [NCOMP],
                                   input int base, input logic [THR_W-1:0] thr);
    longint d;
    longint acc;
    acc = 0;
    for (int k = base; k < base + GATE_N; k++) begin
      d = avg[k] - smp[k];
      if (d < 0) d = -d;
      if (d >= longint'(thr)) return 1'b0;
      acc += d * d;
    end
    return acc < longint'(thr) * longint'(thr);
  endfunction

  // Advance the averager by one beat; returns 1 when a result beat is due.
  function automatic bit smooth_pose(input logic marker, input pose_t raw,
                                     output pose_beat_t beat);
    longint smp [NCOMP];
    longint avg [NCOMP];
    bit     give_mean;
    beat = '0;
    give_mean = 1'b0;
    for (int k = 0; k < NCOMP; k++)
      smp[k] = longint'($signed(raw[k]));
    if (!marker) begin
      if (n_held == 0) return 1'b0;
      mean_of(avg);
      give_mean = 1'b1;
    end else begin
      if (n_held == 0) begin
        pose_sum = smp;
        n_held = CNT_W'(1);
      end
      mean_of(avg);
      if (gate_open(avg, smp, 0, trans_gate) && gate_open(avg, smp, GATE_N, rot_gate)) begin
        if (n_held < hold_cap) begin
          for (int k = 0; k < NCOMP; k++)
            pose_sum[k] += smp[k];
          n_held++;
        end else begin
          give_mean = 1'b1;
        end
      end else begin
        pose_sum = smp;
        n_held = CNT_W'(1);
      end
    end
    beat.from_mean = give_mean;
    for (int k = 0; k < NCOMP; k++)
      beat.comp[k] = give_mean ? CW'(avg[k]) : raw[k];
    return 1'b1;
  endfunction

  always @(posedge clk) begin : score
    pose_beat_t want;
    pose_beat_t got;
    if (!rst_n) begin
      trans_gate = TRANS_THR_RST;
      rot_gate = ROT_THR_RST;
      hold_cap = COUNT_CAP_RST;
      n_held = '0;
      for (int k = 0; k < NCOMP; k++)
        pose_sum[k] = 0;
      poses_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TRANS_THR: trans_gate = cfg_wdata;
          CFG_ROT_THR:   rot_gate = cfg_wdata;
          CFG_COUNT_CAP: hold_cap = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // Check the result beat before predicting from a new input beat.
      if (out_pose.valid && out_pose.ready) begin
        got.from_mean = out_pose.from_mean;
        got.comp = {out_pose.out_rot_z, out_pose.out_rot_y, out_pose.out_rot_x,
                    out_pose.out_trans_z, out_pose.out_trans_y, out_pose.out_trans_x};
        if (poses_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, expected none actual %h",
                   $time, got);
        end else begin
          want = poses_due.pop_front();
          if (want.from_mean !== got.from_mean) begin
            mismatches++;
            $display("%0t: from_mean expected %b actual %b", $time,
                     want.from_mean, got.from_mean);
          end
          for (int k = 0; k < NCOMP; k++) begin
            if (want.comp[k] !== got.comp[k]) begin
              mismatches++;
              $display("%0t: %s expected %h actual %h", $time, comp_name[k],
                       want.comp[k], got.comp[k]);
            end
          end
        end
      end
      if (in_pose.valid && in_pose.ready) begin
        if (smooth_pose(in_pose.marker_seen,
                        {in_pose.rot_z, in_pose.rot_y, in_pose.rot_x,
                         in_pose.trans_z, in_pose.trans_y, in_pose.trans_x}, want))
          poses_due.insert(poses_due.size(), want);
      end
    end
    pending <= poses_due.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the gated pose averager bench: clock, reset, stimulus, stalls on the
// result channel and the final verdict.
// Depends on gpa_pkg, gpa_in_if, gpa_out_if, gated_pose_averager and gpa_average_checker.
module testbench;
  import gpa_pkg::*;

  typedef logic [NCOMP-1:0][CW-1:0] pose_t;

  // Longer than one item's work in the block, so a dropped beat has settled.
  localparam int DRAIN_CYCLES = 60;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0] cfg_wdata;
  logic             calm;        // high: neither side idles
  logic [THR_W-1:0] trans_gate;  // gates last written, for shaping the jitter
  logic [THR_W-1:0] rot_gate;
  int               mismatches;
  int               pending;

  gpa_in_if  in_pose ();
  gpa_out_if out_pose ();

  gated_pose_averager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pose   (in_pose),
    .out_pose  (out_pose),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gpa_average_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pose    (in_pose),
    .out_pose   (out_pose),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Hard stop well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stall the result channel now and then: mostly short, sometimes long
  // enough that the next beat completes behind a held result.
  initial begin : result_stalls
    int hold;
    out_pose.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < 5) begin
        out_pose.ready <= 1'b0;
        hold = ($urandom_range(0, 99) < 4) ? $urandom_range(50, 90) : $urandom_range(1, 4);
        repeat (hold) @(posedge clk);
        out_pose.ready <= 1'b1;
      end else begin
        out_pose.ready <= 1'b1;
      end
    end
  end

  // Pick a base pose: small values round zero, values near the signed
  // extremes, or any bit pattern at all.
  function automatic pose_t random_pose();
    pose_t p;
    int    flavour;
    flavour = $urandom_range(0, 3);
    for (int k = 0; k < NCOMP; k++) begin
      case (flavour)
        0:       p[k] = CW'($urandom_range(0, 2097151)) - CW'(1048576);
        1:       p[k] = ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000)
                        ^ CW'($urandom_range(0, 65535));
        default: p[k] = $urandom;
      endcase
    end
    return p;
  endfunction

  // Scatter a pose by up to +/-amp per component (wraps at the field width).
  function automatic pose_t jitter(input pose_t base, input int tamp, input int ramp);
    pose_t p;
    int    amp;
    for (int k = 0; k < NCOMP; k++) begin
      amp = (k < GATE_N) ? tamp : ramp;
      p[k] = base[k] + CW'($urandom_range(0, 2 * amp)) - CW'(amp);
    end
    return p;
  endfunction

  // After a random gap unless calm, drive one beat and hold it until the block takes it.
  task automatic send_beat(input logic marker, input pose_t p);
    int gap;
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_pose.valid <= 1'b0;
      gap = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 60) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_pose.valid       <= 1'b1;
    in_pose.marker_seen <= marker;
    in_pose.trans_x     <= p[0];
    in_pose.trans_y     <= p[1];
    in_pose.trans_z     <= p[2];
    in_pose.rot_x       <= p[3];
    in_pose.rot_y       <= p[4];
    in_pose.rot_z       <= p[5];
    do @(posedge clk); while (!in_pose.ready);
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain_results();
    in_pose.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back once the block is idle; junk
  // lands in the spare bits above the count cap.
  task automatic set_config(input logic [THR_W-1:0] tgate, input logic [THR_W-1:0] rgate,
                            input logic [CNT_W-1:0] cap, input logic [7:0] junk);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRANS_THR;
    cfg_wdata <= tgate;
    @(posedge clk);
    cfg_index <= CFG_ROT_THR;
    cfg_wdata <= rgate;
    @(posedge clk);
    cfg_index <= CFG_COUNT_CAP;
    cfg_wdata <= {junk, cap};
    @(posedge clk);
    cfg_we     <= 1'b0;
    trans_gate = tgate;
    rot_gate   = rgate;
  endtask

  // One well-formed run: samples scattered round a common base, mostly well
  // inside both gates, some out to the gate edge, with the odd empty frame.
  task automatic send_run(input int len);
    pose_t base;
    base = random_pose();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_beat(1'b0, random_pose());
      else if ($urandom_range(0, 99) < 20)
        send_beat(1'b1, jitter(base, int'(trans_gate), int'(rot_gate)));
      else
        send_beat(1'b1, jitter(base, int'(trans_gate) / 4, int'(rot_gate) / 4));
    end
  endtask

  // Mostly runs round a base, the rest loose samples and empty frames.
  task automatic run_phase(input int n_items, input int max_run);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, max_run);
        send_run(len);
        sent += len;
      end else if (pick < 88) begin
        send_beat(1'($urandom_range(0, 1)), random_pose());
        sent++;
      end else begin
        send_beat(1'b0, random_pose());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    pose_t p;
    // Every input known from time zero.
    rst_n               = 1'b0;
    calm                = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_TRANS_THR;
    cfg_wdata           = '0;
    trans_gate          = TRANS_THR_RST;
    rot_gate            = ROT_THR_RST;
    in_pose.valid       = 1'b0;
    in_pose.marker_seen = 1'b0;
    in_pose.trans_x     = '0;
    in_pose.trans_y     = '0;
    in_pose.trans_z     = '0;
    in_pose.rot_x       = '0;
    in_pose.rot_y       = '0;
    in_pose.rot_z       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset gates and cap.
    // Empty frame with no average: dropped, nothing comes out.
    send_beat(1'b0, '0);
    // First sample into an empty average is counted twice.
    send_beat(1'b1, '0);
    // Far jump to the positive extreme reseeds.
    send_beat(1'b1, {NCOMP{32'h7fff_ffff}});
    // Just inside the translation gate on one axis.
    p = {NCOMP{32'h7fff_ffff}};
    p[0] = p[0] - CW'(1965);
    send_beat(1'b1, p);
    // Empty frame repeats the truncated mean.
    send_beat(1'b0, '0);
    // Negative extreme, then a rotation difference exactly at the gate.
    send_beat(1'b1, {NCOMP{32'h8000_0000}});
    p = {NCOMP{32'h8000_0000}};
    p[5] = p[5] + CW'(6554);
    send_beat(1'b1, p);
    // Each axis inside the gate but the squared sum beyond it.
    send_beat(1'b1, {NCOMP{32'hffff_ffff}});
    p = {NCOMP{32'hffff_ffff}};
    p[0] = p[0] - CW'(1500);
    p[1] = p[1] - CW'(1500);
    send_beat(1'b1, p);
    // Alternating bit patterns, repeated so they average.
    send_beat(1'b1, {3{32'h5555_5555, 32'haaaa_aaaa}});
    send_beat(1'b1, {3{32'h5555_5555, 32'haaaa_aaaa}});
    send_beat(1'b1, {3{32'h5555_5555, 32'haaaa_aaaa}});
    // Empty frame with garbage in the pose fields.
    send_beat(1'b0, {NCOMP{32'hdead_beef}});

    // Zero gates: nothing is ever close, every sample reseeds.
    set_config('0, '0, CNT_W'(5), 8'h00);
    run_phase(60, 10);
    // Widest gates with a cap of one: the held mean comes out at once.
    set_config(16'hffff, 16'hffff, CNT_W'(1), 8'h00);
    run_phase(80, 10);
    // Cap of zero, junk in the spare bits: averaging never proceeds.
    set_config(TRANS_THR_RST, ROT_THR_RST, CNT_W'(0), 8'ha5);
    run_phase(60, 10);
    // Gates of one: only an exact repeat of the mean is close.
    set_config(16'd1, 16'd1, CNT_W'(2), 8'h00);
    run_phase(40, 8);
    // Narrow gates, small cap.
    set_config(16'd400, 16'd900, CNT_W'(8), 8'h00);
    run_phase(200, 20);
    // Largest cap: one long run to reach it, then the usual mix.
    set_config(16'hffff, 16'hffff, CNT_W'(255), 8'h00);
    send_run(270);
    run_phase(80, 40);
    // Back to the reset settings; open with a stretch where nobody idles.
    set_config(TRANS_THR_RST, ROT_THR_RST, COUNT_CAP_RST, 8'h00);
    calm <= 1'b1;
    send_run(150);
    calm <= 1'b0;
    run_phase(200, 120);

    drain_results();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
